// ===== src/ile_pkg.sv =====
// Shared constants and types of the indexed list engine.
package ile_pkg;

	localparam int unsigned CAPACITY_DEF     = 64;
	localparam int unsigned HANDLE_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_REPLACE = 3'd2,
		OP_READ    = 3'd3,
		OP_REMOVE  = 3'd4,
		OP_FIND    = 3'd5,
		OP_CLEAR   = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_BAD_INDEX = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_FETCH    = 6'b000010,
		S_SHIFT_UP = 6'b000100,
		S_PLACE    = 6'b001000,
		S_SHIFT_DN = 6'b010000,
		S_SCAN     = 6'b100000
	} state_t;

endpackage

// ===== src/ile_ram.sv =====
// Entry store: one write port and one registered read port.
module ile_ram #(
	parameter int unsigned DEPTH = ile_pkg::CAPACITY_DEF,
	parameter int unsigned WIDTH = ile_pkg::HANDLE_WIDTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/indexed_list_engine.sv =====
// Top level of the indexed list engine: request sequencer around the entry store.
//
// A request beat (op, position, handle) is taken at a rising edge where start is
// high and busy is low. Exactly one result beat follows, shown for one cycle with
// done high, carrying status, handle_out, found_position, entry_count and
// is_empty. The receiver cannot stall; it must take each result as it appears.
// Path from the accepting edge to the result beat, per operation:
//   append, replace, clear, unknown op and every rejected request: result in the
//     next cycle, and busy stays low, so a new request may follow at once.
//   read: through S_FETCH, which takes the registered store output.
//   insert: S_SHIFT_UP, then S_PLACE; written at once when position equals count.
//   remove: S_SHIFT_DN moves the entries above position down.
//   find: S_SCAN compares up to count entries, ending early at the first match.
// The long operations are bound by the store's single read port, which moves or
// compares one entry per cycle; the store holds up to CAPACITY entries.
// Reset clears the count and the sequencer. The store itself is not cleared;
// only entries below the count are ever read, and those were written first.
module indexed_list_engine #(
	parameter int unsigned CAPACITY     = ile_pkg::CAPACITY_DEF,
	parameter int unsigned HANDLE_WIDTH = ile_pkg::HANDLE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [6:0]  position,
	input  logic [31:0] handle,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] handle_out,
	output logic [5:0]  found_position,
	output logic [6:0]  entry_count,
	output logic        is_empty
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = (CW > 7) ? CW : 7;
	localparam int unsigned HW = HANDLE_WIDTH;

	ile_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    pos_q, pos_d;
	logic [HW-1:0]    hdl_q, hdl_d;
	logic [AW-1:0]    ptr_q, ptr_d;
	logic             done_q, done_d;
	ile_pkg::status_t status_q, status_d;
	logic [31:0]      hout_q, hout_d;
	logic [5:0]       fpos_q, fpos_d;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [HW-1:0]    mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [HW-1:0]    mem_rdata;

	logic             accept;
	ile_pkg::op_t     op_e;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    cnt_x;
	logic [AW-1:0]    pos_a;
	logic [HW-1:0]    hdl_x;
	logic             full;
	logic             uses_handle;
	logic [AW-1:0]    last_ptr;

	ile_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(HW),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign busy   = (state_q != ile_pkg::S_IDLE);
	assign accept = start && !busy;
	assign op_e   = ile_pkg::op_t'(op);
	assign pos_x  = XW'(position);
	assign cnt_x  = XW'(count_q);
	assign pos_a  = pos_x[AW-1:0];
	assign hdl_x  = HW'(handle);
	assign full   = (count_q == CW'(CAPACITY));
	assign last_ptr = AW'(count_q - CW'(1));
	assign uses_handle = (op_e == ile_pkg::OP_APPEND) || (op_e == ile_pkg::OP_INSERT) ||
		(op_e == ile_pkg::OP_REPLACE) || (op_e == ile_pkg::OP_FIND);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		hdl_d     = hdl_q;
		ptr_d     = ptr_q;
		done_d    = 1'b0;
		status_d  = status_q;
		hout_d    = hout_q;
		fpos_d    = fpos_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ile_pkg::S_IDLE: begin
				if (accept) begin
					pos_d    = pos_a;
					hdl_d    = hdl_x;
					hout_d   = '0;
					fpos_d   = '0;
					status_d = ile_pkg::ST_OK;
					if (uses_handle && (hdl_x == '0)) begin
						status_d = ile_pkg::ST_ZERO;
						done_d   = 1'b1;
					end else begin
						case (op_e)
							ile_pkg::OP_APPEND: begin
								done_d = 1'b1;
								if (full) begin
									status_d = ile_pkg::ST_FULL;
								end else begin
									mem_we    = 1'b1;
									mem_waddr = AW'(count_q);
									mem_wdata = hdl_x;
									count_d   = count_q + CW'(1);
								end
							end
							ile_pkg::OP_INSERT: begin
								if (pos_x > cnt_x) begin
									status_d = ile_pkg::ST_BAD_INDEX;
									done_d   = 1'b1;
								end else if (full) begin
									status_d = ile_pkg::ST_FULL;
									done_d   = 1'b1;
								end else if (pos_x == cnt_x) begin
									mem_we    = 1'b1;
									mem_waddr = pos_a;
									mem_wdata = hdl_x;
									count_d   = count_q + CW'(1);
									done_d    = 1'b1;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = last_ptr;
									ptr_d     = last_ptr;
									state_d   = ile_pkg::S_SHIFT_UP;
								end
							end
							ile_pkg::OP_REPLACE: begin
								done_d = 1'b1;
								if (pos_x >= cnt_x) begin
									status_d = ile_pkg::ST_BAD_INDEX;
								end else begin
									mem_we    = 1'b1;
									mem_waddr = pos_a;
									mem_wdata = hdl_x;
								end
							end
							ile_pkg::OP_READ: begin
								if (pos_x >= cnt_x) begin
									status_d = ile_pkg::ST_BAD_INDEX;
									done_d   = 1'b1;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = pos_a;
									state_d   = ile_pkg::S_FETCH;
								end
							end
							ile_pkg::OP_REMOVE: begin
								if (pos_x >= cnt_x) begin
									status_d = ile_pkg::ST_BAD_INDEX;
									done_d   = 1'b1;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = pos_a;
									ptr_d     = pos_a;
									state_d   = ile_pkg::S_SHIFT_DN;
								end
							end
							ile_pkg::OP_FIND: begin
								if (count_q == '0) begin
									status_d = ile_pkg::ST_NOT_FOUND;
									done_d   = 1'b1;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = '0;
									ptr_d     = '0;
									state_d   = ile_pkg::S_SCAN;
								end
							end
							ile_pkg::OP_CLEAR: begin
								count_d = '0;
								done_d  = 1'b1;
							end
							default: begin
								done_d = 1'b1;
							end
						endcase
					end
				end
			end
			ile_pkg::S_FETCH: begin
				hout_d  = 32'(mem_rdata);
				done_d  = 1'b1;
				state_d = ile_pkg::S_IDLE;
			end
			ile_pkg::S_SHIFT_UP: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q + AW'(1);
				mem_wdata = mem_rdata;
				if (ptr_q == pos_q) begin
					state_d = ile_pkg::S_PLACE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q - AW'(1);
					ptr_d     = ptr_q - AW'(1);
				end
			end
			ile_pkg::S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = hdl_q;
				count_d   = count_q + CW'(1);
				done_d    = 1'b1;
				state_d   = ile_pkg::S_IDLE;
			end
			ile_pkg::S_SHIFT_DN: begin
				if (ptr_q == pos_q) begin
					hout_d = 32'(mem_rdata);
				end else begin
					mem_we    = 1'b1;
					mem_waddr = ptr_q - AW'(1);
					mem_wdata = mem_rdata;
				end
				if (ptr_q == last_ptr) begin
					count_d = count_q - CW'(1);
					done_d  = 1'b1;
					state_d = ile_pkg::S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + AW'(1);
					ptr_d     = ptr_q + AW'(1);
				end
			end
			ile_pkg::S_SCAN: begin
				if (mem_rdata == hdl_q) begin
					fpos_d  = 6'(ptr_q);
					done_d  = 1'b1;
					state_d = ile_pkg::S_IDLE;
				end else if (ptr_q == last_ptr) begin
					status_d = ile_pkg::ST_NOT_FOUND;
					done_d   = 1'b1;
					state_d  = ile_pkg::S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + AW'(1);
					ptr_d     = ptr_q + AW'(1);
				end
			end
			default: begin
				state_d = ile_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ile_pkg::S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		hdl_q    <= hdl_d;
		ptr_q    <= ptr_d;
		status_q <= status_d;
		hout_q   <= hout_d;
		fpos_q   <= fpos_d;
	end

	assign done           = done_q;
	assign status         = status_q;
	assign handle_out     = hout_q;
	assign found_position = fpos_q;
	assign entry_count    = 7'(count_q);
	assign is_empty       = (count_q == '0);

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the indexed list engine: directed and random request traffic.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIST_DEPTH     = ile_pkg::CAPACITY_DEF;
	localparam logic [2:0]  OP_UNDEFINED   = 3'd7;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          END_SETTLE     = 80;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] handle_out;
		logic [5:0]  found_position;
		logic [6:0]  entry_count;
		logic        is_empty;
	} list_response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  op = OP_UNDEFINED;
	logic [6:0]  position = '0;
	logic [31:0] handle = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [31:0] handle_out;
	logic [5:0]  found_position;
	logic [6:0]  entry_count;
	logic        is_empty;

	logic [31:0]    list_mem [LIST_DEPTH];
	int unsigned    list_len = 0;
	list_response_t pending_responses [$];
	int             mismatches = 0;
	int             stall_cycles = 0;
	bit             bursts_on = 1'b1;

	indexed_list_engine u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.position       (position),
		.handle         (handle),
		.done           (done),
		.status         (status),
		.handle_out     (handle_out),
		.found_position (found_position),
		.entry_count    (entry_count),
		.is_empty       (is_empty)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic list_response_t expected_list_response(input logic [2:0] req_op,
			input logic [6:0] req_pos, input logic [31:0] req_handle);
		list_response_t r;
		bit             needs_handle;
		int unsigned    k;
		int unsigned    p;
		r = '0;
		r.status = ile_pkg::ST_OK;
		p = req_pos;
		needs_handle = (req_op == ile_pkg::OP_APPEND) || (req_op == ile_pkg::OP_INSERT) ||
			(req_op == ile_pkg::OP_REPLACE) || (req_op == ile_pkg::OP_FIND);
		if (needs_handle && req_handle == '0) begin
			r.status = ile_pkg::ST_ZERO;
		end else begin
			case (req_op)
				ile_pkg::OP_APPEND: begin
					if (list_len >= LIST_DEPTH) begin
						r.status = ile_pkg::ST_FULL;
					end else begin
						list_mem[list_len] = req_handle;
						list_len++;
					end
				end
				ile_pkg::OP_INSERT: begin
					if (p > list_len) begin
						r.status = ile_pkg::ST_BAD_INDEX;
					end else if (list_len >= LIST_DEPTH) begin
						r.status = ile_pkg::ST_FULL;
					end else begin
						for (k = list_len; k > p; k--)
							list_mem[k] = list_mem[k - 1];
						list_mem[p] = req_handle;
						list_len++;
					end
				end
				ile_pkg::OP_REPLACE: begin
					if (p >= list_len)
						r.status = ile_pkg::ST_BAD_INDEX;
					else
						list_mem[p] = req_handle;
				end
				ile_pkg::OP_READ: begin
					if (p >= list_len)
						r.status = ile_pkg::ST_BAD_INDEX;
					else
						r.handle_out = list_mem[p];
				end
				ile_pkg::OP_REMOVE: begin
					if (p >= list_len) begin
						r.status = ile_pkg::ST_BAD_INDEX;
					end else begin
						r.handle_out = list_mem[p];
						for (k = p; k + 1 < list_len; k++)
							list_mem[k] = list_mem[k + 1];
						list_len--;
					end
				end
				ile_pkg::OP_FIND: begin
					r.status = ile_pkg::ST_NOT_FOUND;
					for (k = 0; k < list_len; k++) begin
						if (list_mem[k] == req_handle) begin
							r.status = ile_pkg::ST_OK;
							r.found_position = 6'(k);
							break;
						end
					end
				end
				ile_pkg::OP_CLEAR: begin
					list_len = 0;
				end
				default: begin
				end
			endcase
		end
		r.entry_count = 7'(list_len);
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	task automatic send_request(input logic [2:0] req_op, input logic [6:0] req_pos,
			input logic [31:0] req_handle);
		op <= req_op;
		position <= req_pos;
		handle <= req_handle;
		start <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_responses.push_back(expected_list_response(req_op, req_pos, req_handle));
	endtask

	// A pause drops start and puts noise on the request fields, which must be ignored.
	task automatic sender_pause();
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			op <= 3'($urandom);
			position <= 7'($urandom);
			handle <= $urandom;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_responses.size() != 0);
	endtask

	task automatic issue(input logic [2:0] req_op, input logic [6:0] req_pos,
			input logic [31:0] req_handle);
		send_request(req_op, req_pos, req_handle);
		sender_pause();
	endtask

	function automatic logic [6:0] pick_position(input logic [2:0] req_op);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			if (req_op == ile_pkg::OP_INSERT)
				return 7'($urandom_range(0, list_len));
			if (list_len == 0)
				return '0;
			return 7'($urandom_range(0, list_len - 1));
		end
		if (r < 95)
			return 7'($urandom_range(0, LIST_DEPTH));
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic logic [31:0] pick_handle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 50 && list_len > 0)
			return list_mem[$urandom_range(0, list_len - 1)];
		if (r < 53)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic test_empty_list();
		issue(ile_pkg::OP_READ, 7'd0, 32'h0000_0005);
		issue(ile_pkg::OP_REMOVE, 7'd0, 32'h0000_0005);
		issue(ile_pkg::OP_REPLACE, 7'd0, 32'h0000_0005);
		issue(ile_pkg::OP_FIND, 7'd0, 32'h0000_0005);
		issue(ile_pkg::OP_INSERT, 7'd1, 32'h0000_0003);
		issue(ile_pkg::OP_APPEND, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_INSERT, 7'd100, 32'h0000_0000);
		issue(OP_UNDEFINED, 7'd0, 32'h0000_0009);
		issue(ile_pkg::OP_CLEAR, 7'd0, 32'h0000_0000);
	endtask

	task automatic test_list_editing();
		issue(ile_pkg::OP_APPEND, 7'd0, 32'hFFFF_FFFF);
		issue(ile_pkg::OP_APPEND, 7'd0, 32'h0000_0001);
		issue(ile_pkg::OP_INSERT, 7'd0, 32'hA5A5_0001);
		issue(ile_pkg::OP_INSERT, 7'd3, 32'h0000_5A5A);
		issue(ile_pkg::OP_INSERT, 7'd2, 32'h0000_0001);
		issue(ile_pkg::OP_FIND, 7'd0, 32'h0000_0001);
		issue(ile_pkg::OP_REPLACE, 7'd1, 32'h8000_0000);
		issue(ile_pkg::OP_READ, 7'd1, 32'h0000_0000);
		issue(ile_pkg::OP_READ, 7'd64, 32'h0000_0000);
		issue(ile_pkg::OP_REMOVE, 7'd127, 32'h0000_0000);
		issue(ile_pkg::OP_REMOVE, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_FIND, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_READ, 7'd4, 32'h0000_0000);
		issue(OP_UNDEFINED, 7'd3, 32'h1234_5678);
		issue(ile_pkg::OP_CLEAR, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_READ, 7'd0, 32'h0000_0000);
	endtask

	task automatic test_full_store();
		logic [31:0] h;
		int          i;
		for (i = 0; i < LIST_DEPTH - 1; i++) begin
			h = $urandom;
			if (h == '0)
				h = 32'h0000_0001;
			issue(ile_pkg::OP_APPEND, 7'd0, h);
		end
		issue(ile_pkg::OP_APPEND, 7'd0, 32'hFFFF_FFFF);
		wait_drained();
		issue(ile_pkg::OP_APPEND, 7'd0, 32'h0000_0077);
		issue(ile_pkg::OP_INSERT, 7'd10, 32'h0000_0077);
		issue(ile_pkg::OP_INSERT, 7'd64, 32'h0000_0077);
		issue(ile_pkg::OP_INSERT, 7'd65, 32'h0000_0077);
		issue(ile_pkg::OP_APPEND, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_FIND, 7'd0, 32'hFFFF_FFFF);
		issue(ile_pkg::OP_READ, 7'd63, 32'h0000_0000);
		issue(ile_pkg::OP_REMOVE, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_INSERT, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_INSERT, 7'd0, 32'h0BAD_F00D);
		issue(ile_pkg::OP_REMOVE, 7'd63, 32'h0000_0000);
		issue(ile_pkg::OP_REPLACE, 7'd62, 32'h0000_0042);
		issue(ile_pkg::OP_FIND, 7'd0, 32'h0000_0000);
		issue(ile_pkg::OP_FIND, 7'd0, 32'hFFFF_FFFE);
		wait_drained();
		issue(ile_pkg::OP_CLEAR, 7'd0, 32'h0000_0000);
	endtask

	task automatic test_random_traffic(input int n_items, input int grow_pct,
			input int shrink_pct);
		logic [2:0]  req_op;
		int unsigned r;
		int          n;
		for (n = 0; n < n_items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 1)
				req_op = ile_pkg::OP_CLEAR;
			else if (r < 3)
				req_op = OP_UNDEFINED;
			else if (r < 3 + grow_pct)
				req_op = $urandom_range(0, 1) ? ile_pkg::OP_APPEND : ile_pkg::OP_INSERT;
			else if (r < 3 + grow_pct + shrink_pct)
				req_op = ile_pkg::OP_REMOVE;
			else begin
				r = $urandom_range(0, 9);
				req_op = (r < 4) ? ile_pkg::OP_FIND :
					(r < 7) ? ile_pkg::OP_READ : ile_pkg::OP_REPLACE;
			end
			send_request(req_op, pick_position(req_op), pick_handle());
			if ($urandom_range(0, 49) == 0)
				wait_drained();
			else
				sender_pause();
		end
	endtask

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		list_response_t want;
		if (arst_n && done !== 1'b0) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: result beat with nothing outstanding, status %0h", $time,
					status);
				mismatches++;
			end else begin
				want = pending_responses.pop_front();
				report_field("status", 32'(want.status), 32'(status));
				report_field("handle_out", want.handle_out, handle_out);
				report_field("found_position", 32'(want.found_position),
					32'(found_position));
				report_field("entry_count", 32'(want.entry_count), 32'(entry_count));
				report_field("is_empty", 32'(want.is_empty), 32'(is_empty));
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_list_editing();
		test_full_store();
		test_random_traffic(150, 40, 10);
		test_random_traffic(150, 10, 40);
		test_random_traffic(150, 25, 22);
		bursts_on = 1'b0;
		test_random_traffic(100, 25, 22);
		wait_drained();
		repeat (END_SETTLE)
			@(posedge clk);
		if (mismatches == 0 && pending_responses.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ile_pkg.sv
src/ile_ram.sv
src/indexed_list_engine.sv
test/tb_top.sv
